// ----- hw/rtl/ctc_pkg.sv -----
// ----------------------------------------------------------------------------
// ctc_pkg: shared types and constants of the columnar transposition cipher
// Field widths, status codes, register selects, state types and the control
// structs exchanged between the top level and the address walker.
// ----------------------------------------------------------------------------
package ctc_pkg;

   // Field widths fixed by the interface
   localparam int CHAR_W = 8;
   localparam int KEY_W  = 7;
   localparam int STAT_W = 3;

   // Result status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STAT_W-1:0] STAT_NONLETTER = 3'd1;
   localparam logic [STAT_W-1:0] STAT_KEY_LONG  = 3'd2;
   localparam logic [STAT_W-1:0] STAT_KEY_SHORT = 3'd3;
   localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 3'd4;

   // Register select (address bit 2)
   localparam logic CSR_SEL_KEY = 1'b0;
   localparam logic CSR_SEL_DIR = 1'b1;

   // Reset values of the registers
   localparam logic [KEY_W-1:0] KEY_RESET = 7'd2;
   localparam logic             DIR_RESET = 1'b0;

   // Character constants
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_UP_A    = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UP_Z    = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LO_A    = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LO_Z    = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_CASE_MASK = 8'hDF;

   // Top-level message sequencer
   typedef enum logic [1:0] {
      S_LOAD,
      S_CHECK,
      S_WALK,
      S_ERROR
   } ctc_state_type;

   // Address walker sequencer
   typedef enum logic [1:0] {
      W_IDLE,
      W_DIV,
      W_ENC,
      W_DEC
   } walk_state_type;

   typedef struct packed {
      logic start;
      logic decrypt;
   } walk_ctrl_type;

   typedef struct packed {
      logic valid;
      logic last;
   } walk_stat_type;

endpackage

// ----- hw/rtl/columnar_transposition_cipher.sv -----
// ----------------------------------------------------------------------------
// columnar_transposition_cipher: columnar transposition with a column-count key
// Loads a message a byte at a time, then emits the transposed letters or
// a single error status.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel takes one message byte per transaction, one per cycle
//   while loading. Spaces are dropped, letters uppercased into the store,
//   other bytes flag status 1. req_in_last closes the message; req_stall then
//   stays high until the last read of the message has been issued, or until
//   the error transaction has entered the output register.
//   The cycle after the closing byte checks the key. An error gives one
//   response with out_char 0, loaded from the error state into the output
//   register. Encryption then streams one letter per cycle while the receiver
//   does not stall; decryption first counts the table rows by repeated
//   addition of the key, then streams one letter per cycle in the same way.
//   The response channel has a read-data stage and an output register, so a
//   stalled receiver only pauses the walk; nothing is lost or repeated, and
//   the next message can load while the final letters wait to be taken.
//   Reset (synchronous) empties the message, key_columns = 2, direction = 0.
//   Registers: offset 0 key_columns, offset 4 direction; write while idle.
// ----------------------------------------------------------------------------
module columnar_transposition_cipher import ctc_pkg::*; #(
   parameter int MAX_LEN = 64
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CHAR_W-1:0] req_in_char,
   input  logic              req_in_last,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CHAR_W-1:0] rsp_out_char,
   output logic [STAT_W-1:0] rsp_status,
   output logic              rsp_out_last,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int AW = $clog2(MAX_LEN);
   localparam int SW = ((CW > KEY_W) ? CW : KEY_W) + 1;

   ctc_state_type      state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [STAT_W-1:0]  err_ff, err_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic               dir_ff, dir_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_last_ff, s1_last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [CHAR_W-1:0]  rd_data_ff;

   logic [CHAR_W-1:0]  store_mem [MAX_LEN];

   logic               req_accept;
   logic               is_upper;
   logic               is_lower;
   logic               store_en;
   logic [CHAR_W-1:0]  letter_char;
   logic               out_free;
   logic               issue;
   logic               csr_write;
   logic [STAT_W-1:0]  err_final;
   logic [SW-1:0]      key_ext;
   logic [SW-1:0]      count_ext;

   walk_ctrl_type      walk_ctrl;
   walk_stat_type      walk_stat;
   logic [AW-1:0]      walk_addr;

   // Address walker
   ctc_walk #(
      .MAX_LEN (MAX_LEN)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (walk_ctrl),
      .advance   (issue),
      .n_letters (count_ff),
      .n_cols    (CW'(key_ff)),
      .stat      (walk_stat),
      .rd_addr   (walk_addr)
   );

   // Classify the incoming byte
   assign req_accept  = req_valid && !req_stall;
   assign is_upper    = (req_in_char >= CHAR_UP_A) && (req_in_char <= CHAR_UP_Z);
   assign is_lower    = (req_in_char >= CHAR_LO_A) && (req_in_char <= CHAR_LO_Z);
   assign letter_char = req_in_char & CHAR_CASE_MASK;
   assign store_en    = req_accept && (is_upper || is_lower) && (count_ff < CW'(MAX_LEN));

   // Output handshake and read issue
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign issue    = (state_ff == S_WALK) && walk_stat.valid && (!s1_valid_ff || out_free);

   assign key_ext   = SW'(key_ff);
   assign count_ext = SW'(count_ff);
   assign csr_write = psel && penable && pwrite && pready;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         err_ff       <= STAT_OK;
         key_ff       <= KEY_RESET;
         dir_ff       <= DIR_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         key_ff       <= key_in;
         dir_ff       <= dir_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_last_ff    <= s1_last_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Letter store: write while loading, registered read during the walk
   always_ff @(posedge clock) begin
      if (store_en) begin
         store_mem[count_ff[AW-1:0]] <= letter_char;
      end
      if (issue) begin
         rd_data_ff <= store_mem[walk_addr];
      end
   end

   // Key check on the closed message
   always_comb begin
      priority if (err_ff != STAT_OK) begin
         err_final = err_ff;
      end else if (key_ext > count_ext) begin
         err_final = STAT_KEY_LONG;
      end else if ((key_ff == KEY_W'(0)) || (key_ff == KEY_W'(1)) ||
                   (key_ext == count_ext)) begin
         err_final = STAT_KEY_SHORT;
      end else begin
         err_final = STAT_OK;
      end
   end

   // Message sequencer, register writes and response path
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      key_in        = key_ff;
      dir_in        = dir_ff;
      s1_valid_in   = s1_valid_ff;
      s1_last_in    = s1_last_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      walk_ctrl     = '0;
      req_stall     = (state_ff != S_LOAD);

      // register writes
      if (csr_write) begin
         unique case (paddr[2])
            CSR_SEL_KEY: key_in = pwdata[KEY_W-1:0];
            CSR_SEL_DIR: dir_in = pwdata[0];
            default:     key_in = key_ff;
         endcase
      end

      unique case (state_ff)
         S_LOAD: begin
            if (req_accept) begin
               if (store_en) begin
                  count_in = count_ff + CW'(1);
               end else if ((req_in_char != CHAR_SPACE) && (err_ff == STAT_OK)) begin
                  err_in = (is_upper || is_lower) ? STAT_OVERFLOW : STAT_NONLETTER;
               end
               if (req_in_last) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (err_final != STAT_OK) begin
               err_in   = err_final;
               state_in = S_ERROR;
            end else begin
               walk_ctrl.start   = 1'b1;
               walk_ctrl.decrypt = dir_ff;
               state_in          = S_WALK;
            end
         end
         S_WALK: begin
            // drop the message once its final read is out
            if (issue && walk_stat.last) begin
               count_in = '0;
               err_in   = STAT_OK;
               state_in = S_LOAD;
            end
         end
         S_ERROR: begin
            if (!s1_valid_ff && out_free) begin
               count_in = '0;
               err_in   = STAT_OK;
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      // read-data stage
      if (issue) begin
         s1_valid_in = 1'b1;
         s1_last_in  = walk_stat.last;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end

      // output register: letters first, then an error transaction
      if (out_free) begin
         if (s1_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_char_in   = rd_data_ff;
            rsp_status_in = STAT_OK;
            rsp_last_in   = s1_last_ff;
         end else if (state_ff == S_ERROR) begin
            rsp_valid_in  = 1'b1;
            rsp_char_in   = '0;
            rsp_status_in = err_ff;
            rsp_last_in   = 1'b1;
         end else begin
            rsp_valid_in  = 1'b0;
         end
      end
   end

   // Register readback
   always_comb begin
      unique case (paddr[2])
         CSR_SEL_KEY: prdata = {{(32-KEY_W){1'b0}}, key_ff};
         CSR_SEL_DIR: prdata = {31'b0, dir_ff};
         default:     prdata = '0;
      endcase
   end

   assign pready       = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_out_last = rsp_last_ff;

endmodule

// ----- hw/rtl/ctc_walk.sv -----
// ----------------------------------------------------------------------------
// ctc_walk: read-address walker for the letter store
// Generates the store addresses of one message in output order, one per
// advance. Decrypt first counts the table rows by repeated addition of the
// key.
// ----------------------------------------------------------------------------
module ctc_walk import ctc_pkg::*; #(
   parameter int MAX_LEN = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  walk_ctrl_type                      ctrl,
   input  logic                               advance,
   input  logic [$clog2(MAX_LEN+1)-1:0]       n_letters,
   input  logic [$clog2(MAX_LEN+1)-1:0]       n_cols,
   output walk_stat_type                      stat,
   output logic [$clog2(MAX_LEN)-1:0]         rd_addr
);

   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int AW = $clog2(MAX_LEN);
   localparam int SW = CW + 1;

   walk_state_type state_ff, state_in;
   logic [CW-1:0]  pos_ff, pos_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [CW-1:0]  acc_ff, acc_in;
   logic [CW-1:0]  rows_ff, rows_in;
   logic [CW-1:0]  rem_ff, rem_in;
   logic [CW-1:0]  base_ff, base_in;
   logic [CW-1:0]  lidx_ff, lidx_in;

   logic [SW-1:0]  acc_sum;
   logic [SW-1:0]  pos_step;
   logic [CW-1:0]  col_next;
   logic [CW-1:0]  len_next;

   // Hold the sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold the walk counters
   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      col_ff  <= col_in;
      acc_ff  <= acc_in;
      rows_ff <= rows_in;
      rem_ff  <= rem_in;
      base_ff <= base_in;
      lidx_ff <= lidx_in;
   end

   // Advance the walk
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      col_in   = col_ff;
      acc_in   = acc_ff;
      rows_in  = rows_ff;
      rem_in   = rem_ff;
      base_in  = base_ff;
      lidx_in  = lidx_ff;
      stat     = '0;
      rd_addr  = pos_ff[AW-1:0];

      acc_sum  = {1'b0, acc_ff} + {1'b0, n_cols};
      pos_step = {1'b0, pos_ff} + {1'b0, n_cols};
      col_next = col_ff + CW'(1);
      // columns left of the remainder hold a full row count
      len_next = (col_next < rem_ff) ? rows_ff : rows_ff - CW'(1);

      unique case (state_ff)
         W_IDLE: begin
            if (ctrl.start) begin
               if (ctrl.decrypt) begin
                  acc_in   = '0;
                  rows_in  = '0;
                  state_in = W_DIV;
               end else begin
                  col_in   = n_cols - CW'(1);
                  pos_in   = n_cols - CW'(1);
                  state_in = W_ENC;
               end
            end
         end
         W_DIV: begin
            // count rows: add the key until the letter count is reached
            acc_in  = acc_sum[CW-1:0];
            rows_in = rows_ff + CW'(1);
            if (acc_sum >= {1'b0, n_letters}) begin
               rem_in   = n_letters - acc_ff;
               base_in  = n_letters - rows_ff - CW'(1);
               lidx_in  = n_letters - rows_ff - CW'(1);
               pos_in   = '0;
               col_in   = '0;
               state_in = W_DEC;
            end
         end
         W_ENC: begin
            // columns from last to first, each top to bottom
            stat.valid = 1'b1;
            stat.last  = (col_ff == '0) && (pos_step >= {1'b0, n_letters});
            rd_addr    = pos_ff[AW-1:0];
            if (advance) begin
               if (pos_step < {1'b0, n_letters}) begin
                  pos_in = pos_step[CW-1:0];
               end else if (col_ff == '0) begin
                  state_in = W_IDLE;
               end else begin
                  col_in = col_ff - CW'(1);
                  pos_in = col_ff - CW'(1);
               end
            end
         end
         W_DEC: begin
            // row-major output; track the source index of each cell
            stat.valid = 1'b1;
            stat.last  = ((pos_ff + CW'(1)) == n_letters);
            rd_addr    = lidx_ff[AW-1:0];
            if (advance) begin
               if (stat.last) begin
                  state_in = W_IDLE;
               end else begin
                  pos_in = pos_ff + CW'(1);
                  if (col_next == n_cols) begin
                     col_in  = '0;
                     base_in = base_ff + CW'(1);
                     lidx_in = base_ff + CW'(1);
                  end else begin
                     col_in  = col_next;
                     lidx_in = lidx_ff - len_next;
                  end
               end
            end
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/ctc_checker.sv -----
// ----------------------------------------------------------------------------
// ctc_checker: port-level checks for the columnar transposition cipher
// Watches the response channel for stalled-transaction stability and for
// well-formed letter and error transactions.
// ----------------------------------------------------------------------------
module ctc_checker import ctc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [CHAR_W-1:0] rsp_out_char,
   input logic [STAT_W-1:0] rsp_status,
   input logic              rsp_out_last
);

   // Hold a stalled response transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char) &&
                                 $stable(rsp_status) && $stable(rsp_out_last))
      else $error("stalled response transaction changed");

   // An error transaction is a final item with a zero character
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |-> rsp_out_last && (rsp_out_char == '0))
      else $error("malformed error transaction");

   // A good transaction carries an uppercase letter
   a_ok_letter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_OK) |->
         (rsp_out_char >= CHAR_UP_A) && (rsp_out_char <= CHAR_UP_Z))
      else $error("result letter not uppercase");

   // Status stays within the defined codes
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= STAT_OVERFLOW))
      else $error("undefined status code");

endmodule

bind columnar_transposition_cipher ctc_checker u_ctc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_char (rsp_out_char),
   .rsp_status   (rsp_status),
   .rsp_out_last (rsp_out_last)
);
